FILE: hdl/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg: shared types and constants of the GCD / LCM unit
// Operand widths, sequencer states, datapath commands and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

package glu_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int WIDE_BITS    = 2 * OPERAND_BITS;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_SCALE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } glu_state_t;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_GCD,
        DP_SCALE,
        DP_DIV,
        DP_MUL,
        DP_OUT
    } glu_op_t;

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic any_zero;
    } glu_status_t;

endpackage : glu_pkg

`default_nettype wire

FILE: hdl/glu_alu.sv
// ----------------------------------------------------------------------------
// glu_alu: shared adder / subtractor
// One add or subtract of OPERAND_BITS+1 bits; carry out flags a >= b on subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module glu_alu
    import glu_pkg::*;
(
    input  wire logic [OPERAND_BITS:0] op_a,
    input  wire logic [OPERAND_BITS:0] op_b,
    input  wire logic                  sub,
    output logic      [OPERAND_BITS:0] res,
    output logic                       carry
);

    logic [OPERAND_BITS+1:0] sum;
    logic [OPERAND_BITS:0]   b_eff;

    always_comb
    begin
        b_eff = sub ? ~op_b : op_b;
        sum   = {1'b0, op_a} + {1'b0, b_eff} + {{(OPERAND_BITS+1){1'b0}}, sub};
        res   = sum[OPERAND_BITS:0];
        carry = sum[OPERAND_BITS+1];
    end

endmodule : glu_alu

`default_nettype wire

FILE: hdl/glu_datapath.sv
// ----------------------------------------------------------------------------
// glu_datapath: operand registers and step logic
// Binary GCD steps, restoring divide and shift-add multiply on one shared ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module glu_datapath
    import glu_pkg::*;
(
    input  wire logic                    clk,
    input  wire glu_op_t                 op,
    input  wire logic [OPERAND_BITS-1:0] first_value,
    input  wire logic [OPERAND_BITS-1:0] second_value,
    output glu_status_t                  status,
    output logic      [OPERAND_BITS-1:0] divisor,
    output logic      [WIDE_BITS-1:0]    multiple
);

    logic [OPERAND_BITS-1:0] a_reg, a_next;
    logic [OPERAND_BITS-1:0] b_reg, b_next;
    logic [OPERAND_BITS-1:0] x_reg, x_next;
    logic [OPERAND_BITS-1:0] y_reg, y_next;
    logic [CNT_BITS-1:0]     k_reg, k_next;
    logic [OPERAND_BITS-1:0] g_reg, g_next;
    logic [OPERAND_BITS-1:0] r_reg, r_next;
    logic [OPERAND_BITS-1:0] q_reg, q_next;
    logic [OPERAND_BITS-1:0] hi_reg, hi_next;
    logic [OPERAND_BITS-1:0] div_reg, div_next;
    logic [WIDE_BITS-1:0]    mul_reg, mul_next;

    logic [OPERAND_BITS:0]   alu_a;
    logic [OPERAND_BITS:0]   alu_b;
    logic                    alu_sub;
    logic [OPERAND_BITS:0]   alu_res;
    logic                    alu_carry;
    logic [OPERAND_BITS:0]   mul_sum;
    logic [OPERAND_BITS-1:0] nz_val;
    logic                    any_zero;

    glu_alu u_alu
    (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .carry (alu_carry)
    );

    assign any_zero        = (a_reg == '0) || (b_reg == '0);
    assign status.x_zero   = (x_reg == '0);
    assign status.y_zero   = (y_reg == '0);
    assign status.any_zero = any_zero;
    assign divisor         = div_reg;
    assign multiple        = mul_reg;

    always_comb
    begin
        alu_a   = {1'b0, x_reg};
        alu_b   = {1'b0, y_reg};
        alu_sub = 1'b1;
        case (op)
            DP_DIV:
            begin
                alu_a   = {r_reg, q_reg[OPERAND_BITS-1]};
                alu_b   = {1'b0, g_reg};
                alu_sub = 1'b1;
            end
            DP_MUL:
            begin
                alu_a   = {1'b0, hi_reg};
                alu_b   = {1'b0, b_reg};
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = {1'b0, x_reg};
                alu_b   = {1'b0, y_reg};
                alu_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        k_next   = k_reg;
        g_next   = g_reg;
        r_next   = r_reg;
        q_next   = q_reg;
        hi_next  = hi_reg;
        div_next = div_reg;
        mul_next = mul_reg;
        mul_sum  = q_reg[0] ? alu_res : {1'b0, hi_reg};
        nz_val   = (x_reg == '0) ? y_reg : x_reg;
        case (op)
            DP_LOAD:
            begin
                a_next = first_value;
                b_next = second_value;
                x_next = first_value;
                y_next = second_value;
                k_next = '0;
            end
            DP_GCD:
            begin
                if (x_reg != '0 && y_reg != '0)
                begin
                    if (!x_reg[0] && !y_reg[0])
                    begin
                        x_next = x_reg >> 1;
                        y_next = y_reg >> 1;
                        k_next = k_reg + CNT_BITS'(1);
                    end
                    else if (!x_reg[0])
                    begin
                        x_next = x_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_next = y_reg >> 1;
                    end
                    else if (alu_carry)
                    begin
                        x_next = alu_res[OPERAND_BITS:1];
                    end
                    else
                    begin
                        x_next = y_reg;
                        y_next = x_reg;
                    end
                end
            end
            DP_SCALE:
            begin
                g_next  = nz_val << k_reg;
                r_next  = '0;
                q_next  = a_reg;
                hi_next = '0;
            end
            DP_DIV:
            begin
                r_next = alu_carry ? alu_res[OPERAND_BITS-1:0] : alu_a[OPERAND_BITS-1:0];
                q_next = {q_reg[OPERAND_BITS-2:0], alu_carry};
            end
            DP_MUL:
            begin
                hi_next = mul_sum[OPERAND_BITS:1];
                q_next  = {mul_sum[0], q_reg[OPERAND_BITS-1:1]};
            end
            DP_OUT:
            begin
                div_next = g_reg;
                mul_next = any_zero ? '0 : {hi_reg, q_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        hi_reg  <= hi_next;
        div_reg <= div_next;
        mul_reg <= mul_next;
    end

endmodule : glu_datapath

`default_nettype wire

FILE: hdl/glu_ctrl.sv
// ----------------------------------------------------------------------------
// glu_ctrl: sequencer of the GCD / LCM unit
// Steps one request through GCD, scale, divide and multiply; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module glu_ctrl
    import glu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire glu_status_t status,
    output glu_op_t          op
);

    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(OPERAND_BITS - 1);

    glu_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] step_reg, step_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = DP_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = DP_LOAD;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                op = DP_GCD;
                if (status.x_zero || status.y_zero)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                op         = DP_SCALE;
                step_next  = '0;
                state_next = status.any_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                op        = DP_DIV;
                step_next = step_reg + CNT_BITS'(1);
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                op        = DP_MUL;
                step_next = step_reg + CNT_BITS'(1);
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    op             = DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : glu_ctrl

`default_nettype wire

FILE: hdl/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// A request carries first_value and second_value; the result carries divisor
// (the GCD, zero only when both operands are zero) and multiple (the LCM at
// double width, zero when either operand is zero).
// Input channel in_valid / in_stall: a request is taken while in_stall is low,
// which is only when the sequencer is idle. Output channel out_valid /
// out_stall: the result sits in an output register until taken.
// Sequence: the accept step, a binary GCD, the scale step, then the divide
// and multiply steps on the shared adder, then the load of the output register.
// The divide and multiply are skipped when an operand is zero.
// One request is in flight at a time; the next is taken while the previous
// result still waits at the output. If the receiver stalls, the finished
// result holds in the datapath until the output register frees.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_lcm_unit
    import glu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [OPERAND_BITS-1:0] first_value,
    input  wire logic [OPERAND_BITS-1:0] second_value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic      [OPERAND_BITS-1:0] divisor,
    output logic      [WIDE_BITS-1:0]    multiple
);

    glu_op_t     op;
    glu_status_t status;

    glu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    glu_datapath u_datapath
    (
        .clk          (clk),
        .op           (op),
        .first_value  (first_value),
        .second_value (second_value),
        .status       (status),
        .divisor      (divisor),
        .multiple     (multiple)
    );

endmodule : gcd_lcm_unit

`default_nettype wire

FILE: sim/gcd_lcm_unit_test.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit_test: self-checking bench for the GCD / LCM unit
// Sends operand pairs through the valid / stall request channel, with random
// gaps on the sender and random stalls on the receiver. Every result is
// checked against a GCD and LCM worked out in the bench itself. Stimulus
// starts with zero operands, all-ones operands, coprime and worst-case pairs,
// then random pairs: plain, with shared factors, small, zero, shifted,
// exact multiples and narrowed.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_lcm_unit_test;
    import glu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef bit [OPERAND_BITS-1:0] operand_t;
    typedef bit [WIDE_BITS-1:0]    wide_t;

    typedef struct {
        operand_t first;
        operand_t second;
    } request_t;

    typedef struct {
        operand_t divisor;
        wide_t    multiple;
    } gcd_lcm_t;

    localparam operand_t ALL_ONES      = '1;
    localparam int       RANDOM_COUNT  = 1180;
    localparam int       DRAIN_CYCLES  = 200;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic [OPERAND_BITS-1:0] first_value  = '0;
    logic [OPERAND_BITS-1:0] second_value = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic [OPERAND_BITS-1:0] divisor;
    logic [WIDE_BITS-1:0]    multiple;

    request_t pending_requests[$];
    gcd_lcm_t expected_results[$];

    bit request_taken = 1'b0;
    bit result_taken  = 1'b0;
    int request_gap   = 0;
    int result_hold   = 0;

    int accepted_requests = 0;
    int zero_requests     = 0;
    int checked_results   = 0;
    int mismatches        = 0;

    gcd_lcm_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_value  (first_value),
        .second_value (second_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .divisor      (divisor),
        .multiple     (multiple)
    );

    function automatic gcd_lcm_t gcd_lcm_of(operand_t a, operand_t b);
        operand_t x;
        operand_t y;
        operand_t r;
        gcd_lcm_t res;
        x = a;
        y = b;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        res.divisor = x;
        if (a != 0 && b != 0)
            res.multiple = wide_t'(a / x) * wide_t'(b);
        else
            res.multiple = '0;
        return res;
    endfunction

    // no idling for one stretch in every four hundred requests
    function automatic int draw_wait();
        if ((accepted_requests / 100) % 4 == 3)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic queue_request(operand_t a, operand_t b);
        request_t req;
        req.first  = a;
        req.second = b;
        pending_requests.push_back(req);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // request driver
    always @(negedge clk)
    begin
        logic     next_valid;
        request_t req;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && request_taken)
            begin
                next_valid  = 1'b0;
                request_gap = draw_wait();
            end
            if (!next_valid)
            begin
                if (request_gap > 0)
                    request_gap--;
                else if (pending_requests.size() > 0)
                begin
                    req = pending_requests.pop_front();
                    first_value  <= req.first;
                    second_value <= req.second;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;

            if (result_taken)
                result_hold = draw_wait();
            out_stall <= (result_hold != 0);
            if (out_valid && result_hold != 0)
                result_hold--;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        gcd_lcm_t want;
        if (rst_n)
        begin
            request_taken = in_valid && !in_stall;
            result_taken  = out_valid && !out_stall;
            if (request_taken)
            begin
                expected_results.push_back(gcd_lcm_of(first_value, second_value));
                accepted_requests++;
                if (first_value == 0 || second_value == 0)
                    zero_requests++;
            end
            if (result_taken)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual divisor %0d multiple %0d",
                             $time, divisor, multiple);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_results++;
                    if (divisor !== want.divisor)
                    begin
                        $display("%0t: divisor expected %0d, actual %0d",
                                 $time, want.divisor, divisor);
                        mismatches++;
                    end
                    if (multiple !== want.multiple)
                    begin
                        $display("%0t: multiple expected %0d, actual %0d",
                                 $time, want.multiple, multiple);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        operand_t a;
        operand_t b;
        operand_t t;
        int unsigned k;

        queue_request(0, 0);
        queue_request(0, 1);
        queue_request(1, 0);
        queue_request(0, ALL_ONES);
        queue_request(ALL_ONES, 0);
        queue_request(1, 1);
        queue_request(ALL_ONES, ALL_ONES);
        queue_request(ALL_ONES, 1);
        queue_request(1, ALL_ONES);
        queue_request(ALL_ONES, operand_t'(ALL_ONES - 1));
        queue_request(operand_t'(ALL_ONES - 1), ALL_ONES);
        queue_request(1836311903, 1134903170);
        queue_request(1134903170, 1836311903);
        queue_request(operand_t'(1) << (OPERAND_BITS - 1), operand_t'(3) << (OPERAND_BITS - 2));
        queue_request(12, 18);
        queue_request(18, 12);
        queue_request(operand_t'(1) << (OPERAND_BITS - 1), operand_t'(1) << (OPERAND_BITS - 1));
        queue_request(operand_t'({16{2'b01}}), operand_t'({16{2'b10}}));
        queue_request(ALL_ONES >> 1, operand_t'((ALL_ONES >> 1) + 1));
        queue_request(operand_t'(65536 * 3), operand_t'(65536 * 5));

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    a = operand_t'($urandom);
                    b = operand_t'($urandom);
                end
                3, 4:
                begin
                    k = $urandom_range(1, 65535);
                    a = operand_t'($urandom_range(0, int'(ALL_ONES) / k) * k);
                    b = operand_t'($urandom_range(0, int'(ALL_ONES) / k) * k);
                end
                5:
                begin
                    a = operand_t'($urandom_range(0, 255));
                    b = operand_t'($urandom_range(0, 255));
                end
                6:
                begin
                    a = operand_t'($urandom);
                    b = operand_t'($urandom);
                    case ($urandom_range(0, 3))
                        0: a = 0;
                        1: b = 0;
                        2:
                        begin
                            a = 0;
                            b = 0;
                        end
                        default: b = a;
                    endcase
                end
                7:
                begin
                    a = operand_t'($urandom_range(1, 255)) << $urandom_range(0, OPERAND_BITS - 8);
                    b = operand_t'($urandom_range(1, 255)) << $urandom_range(0, OPERAND_BITS - 8);
                end
                8:
                begin
                    a = operand_t'($urandom_range(1, 65535));
                    b = operand_t'(a * $urandom_range(1, int'(ALL_ONES) / int'(a)));
                    if ($urandom_range(0, 1))
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
                default:
                begin
                    a = operand_t'($urandom >> $urandom_range(0, 31));
                    b = operand_t'($urandom >> $urandom_range(0, 31));
                end
            endcase
            queue_request(a, b);
        end

        @(posedge rst_n);
        while (pending_requests.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d operand pairs (%0d with a zero operand), checked %0d results",
                 accepted_requests, zero_requests, checked_results);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule : gcd_lcm_unit_test

`default_nettype wire
